>>> design/sdcc_pkg.sv
// ----------------------------------------------------------------------------
// sdcc_pkg
// Shared constants and small helpers for the serial day calendar codec.
// ----------------------------------------------------------------------------
package sdcc_pkg;

  localparam int ACC_W    = 25;       // working accumulator, signed
  localparam int SERIAL_W = 23;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int WDAY_W   = 3;
  localparam int EPOCH_W  = 20;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 56;

  localparam int DAYS_Y1   = 365;
  localparam int DAYS_Y4   = DAYS_Y1 * 4 + 1;
  localparam int DAYS_Y100 = DAYS_Y4 * 25 - 1;
  localparam int DAYS_Y400 = DAYS_Y100 * 4 + 1;
  localparam int YEAR_MAX  = 9999;
  localparam int WEEK_LEN  = 7;

  localparam logic [EPOCH_W-1:0] EPOCH_RST = EPOCH_W'(693594);

  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  // month length, idx 0 = January
  function automatic logic [DAY_W-1:0] month_len(input logic lp, input logic [MONTH_W-1:0] idx);
    logic [DAY_W-1:0] r;
    unique case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: r = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   r = 5'd30;
      4'd1:                                      r = lp ? 5'd29 : 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [WDAY_W-1:0] mod7_5(input logic [DAY_W-1:0] v);
    logic [DAY_W-1:0] r;
    r = v;
    if (r >= 5'd28) r = r - 5'd28;
    if (r >= 5'd14) r = r - 5'd14;
    if (r >= 5'd7)  r = r - 5'd7;
    return r[WDAY_W-1:0];
  endfunction

  // (a + b) mod 7 for a, b in 0..6
  function automatic logic [WDAY_W-1:0] add7(input logic [WDAY_W-1:0] a,
                                             input logic [WDAY_W-1:0] b);
    logic [WDAY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'(WEEK_LEN)) s = s - 4'(WEEK_LEN);
    return s[WDAY_W-1:0];
  endfunction

  // 365 = 1 + 4 + 8 + 32 + 64 + 256; the first term seeds the accumulator
  function automatic logic [3:0] mul365_shift(input logic [2:0] step);
    logic [3:0] r;
    unique case (step)
      3'd0:    r = 4'd2;
      3'd1:    r = 4'd3;
      3'd2:    r = 4'd5;
      3'd3:    r = 4'd6;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

endpackage

>>> design/sdcc_core.sv
// ----------------------------------------------------------------------------
// sdcc_core
// Sequencer around one shared 25-bit adder. Decode peels year cycles and
// months off the day count by repeated subtraction; encode builds the
// serial from shifted year terms and month lengths.
// ----------------------------------------------------------------------------
module sdcc_core
  import sdcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [EPOCH_W-1:0]   epoch,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // in_serial_day, in_year, in_month, in_day
  input  logic [0:0]           s_tuser,   // mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // out_serial_day, out_year, out_month, out_day,
                                          // weekday, leap
  output logic [0:0]           m_tuser    // valid_res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DT    = 4'd1;
  localparam logic [3:0] S_DM1   = 4'd2;
  localparam logic [3:0] S_Y400  = 4'd3;
  localparam logic [3:0] S_Y100  = 4'd4;
  localparam logic [3:0] S_Y4    = 4'd5;
  localparam logic [3:0] S_Y1    = 4'd6;
  localparam logic [3:0] S_MON   = 4'd7;
  localparam logic [3:0] S_EDIV  = 4'd8;
  localparam logic [3:0] S_EMUL  = 4'd9;
  localparam logic [3:0] S_ETERM = 4'd10;
  localparam logic [3:0] S_EMON  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]          st;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    opb;
  logic [ACC_W-1:0]    sum;
  logic                neg;
  logic                md;
  logic                vld;
  logic                leap;
  logic [YEAR_W-1:0]   y;      // decode: year; encode: year - 1
  logic [MONTH_W-1:0]  mo;     // encode month
  logic [DAY_W-1:0]    dy;     // encode day
  logic [MONTH_W-1:0]  m;      // month index
  logic [4:0]          cnt;
  logic [6:0]          q100;
  logic [1:0]          b100;
  logic [4:0]          c4;
  logic [WDAY_W-1:0]   wk;     // running day count mod 7

  logic [SERIAL_W-1:0] in_serial;
  logic [YEAR_W-1:0]   in_year;
  logic [MONTH_W-1:0]  in_month;
  logic [DAY_W-1:0]    in_day;
  logic                enc_ok;
  logic                ediv_lp;
  logic [DAY_W-1:0]    mlen;
  logic [WDAY_W-1:0]   wd;
  logic                is_dec;
  logic                load_out;
  logic [OUT_W-1:0]    res_data;

  assign in_serial = s_tdata[22:0];
  assign in_year   = s_tdata[36:23];
  assign in_month  = s_tdata[40:37];
  assign in_day    = s_tdata[45:41];

  assign enc_ok = (in_year != '0) && (in_year <= YEAR_W'(YEAR_MAX)) &&
                  (in_month != '0) && (in_month <= 4'd12) && (in_day != '0);

  assign s_tready = (st == S_IDLE);

  function automatic logic [ACC_W-1:0] neg_of(input logic [ACC_W-1:0] x);
    return ACC_W'(0) - x;
  endfunction

  assign mlen = month_len(leap, m);

  // year % 4 == 0 when (year-1) % 4 == 3; year % 100 == 0 when remainder is 99
  assign ediv_lp = (y[1:0] == 2'd3) && ((acc[6:0] != 7'd99) || (q100[1:0] == 2'd3));

  // operand select for the shared adder
  always_comb begin
    opb = '0;
    unique case (st)
      S_DT:    opb = ACC_W'(epoch);
      S_DM1:   opb = '1;
      S_Y400:  opb = neg_of(ACC_W'(DAYS_Y400));
      S_Y100:  opb = neg_of(ACC_W'(DAYS_Y100));
      S_Y4:    opb = neg_of(ACC_W'(DAYS_Y4));
      S_Y1:    opb = neg_of(ACC_W'(DAYS_Y1));
      S_MON:   opb = neg_of(ACC_W'(mlen));
      S_EDIV:  opb = neg_of(ACC_W'(100));
      S_EMUL:  opb = ACC_W'(y) << mul365_shift(cnt[2:0]);
      S_ETERM: begin
        unique case (cnt[2:0])
          3'd0:    opb = ACC_W'(y >> 2);
          3'd1:    opb = neg_of(ACC_W'(q100));
          3'd2:    opb = ACC_W'(q100 >> 2);
          3'd3:    opb = ACC_W'(dy);
          default: opb = neg_of(ACC_W'(epoch));
        endcase
      end
      S_EMON:  opb = ACC_W'(mlen);
      default: opb = '0;
    endcase
  end

  assign sum = acc + opb;
  assign neg = sum[ACC_W-1];

  assign wd     = add7(add7(wk, mod7_5(acc[DAY_W-1:0])), 3'd1) + 3'd1;
  assign is_dec = (md == MODE_DECODE);

  assign load_out = (st == S_DONE) && (!m_tvalid || m_tready);

  // result word; invalid results carry all-zero fields
  always_comb begin
    res_data = '0;
    if (vld && !is_dec) begin
      res_data[22:0] = acc[SERIAL_W-1:0];
    end
    if (vld && is_dec) begin
      res_data[36:23] = y;
      res_data[40:37] = m + 4'd1;
      res_data[45:41] = acc[DAY_W-1:0] + 5'd1;
      res_data[48:46] = wd;
      res_data[49]    = leap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            md   <= s_tuser[0];
            mo   <= in_month;
            dy   <= in_day;
            wk   <= '0;
            q100 <= '0;
            cnt  <= '0;
            if (s_tuser[0] == MODE_DECODE) begin
              acc <= {{(ACC_W-SERIAL_W){in_serial[SERIAL_W-1]}}, in_serial};
              st  <= S_DT;
            end else if (enc_ok) begin
              acc <= ACC_W'(in_year - 14'd1);
              y   <= in_year - 14'd1;
              st  <= S_EDIV;
            end else begin
              vld <= 1'b0;
              st  <= S_DONE;
            end
          end
        end
        S_DT: begin
          acc <= sum;
          if (neg || (sum == '0)) begin
            vld <= 1'b0;
            st  <= S_DONE;
          end else begin
            vld <= 1'b1;
            st  <= S_DM1;
          end
        end
        S_DM1: begin
          acc <= sum;
          y   <= 14'd1;
          st  <= S_Y400;
        end
        S_Y400: begin
          if (!neg) begin
            acc <= sum;
            y   <= y + 14'd400;
          end else begin
            st <= S_Y100;
          end
        end
        S_Y100: begin
          if ((cnt != 5'd3) && !neg) begin
            acc <= sum;
            y   <= y + 14'd100;
            wk  <= add7(wk, 3'd5);    // 36524 mod 7
            cnt <= cnt + 5'd1;
          end else begin
            b100 <= cnt[1:0];
            cnt  <= '0;
            st   <= S_Y4;
          end
        end
        S_Y4: begin
          if (!neg) begin
            acc <= sum;
            y   <= y + 14'd4;
            wk  <= add7(wk, 3'd5);    // 1461 mod 7
            cnt <= cnt + 5'd1;
          end else begin
            c4  <= cnt;
            cnt <= '0;
            st  <= S_Y1;
          end
        end
        S_Y1: begin
          if ((cnt != 5'd3) && !neg) begin
            acc <= sum;
            y   <= y + 14'd1;
            wk  <= add7(wk, 3'd1);
            cnt <= cnt + 5'd1;
          end else begin
            // leap: last year of a 4-year cycle, unless it closes a
            // century that is not a multiple of 400
            leap <= (cnt == 5'd3) && ((c4 != 5'd24) || (b100 == 2'd3));
            m    <= '0;
            st   <= S_MON;
          end
        end
        S_MON: begin
          if ((m != 4'd11) && !neg) begin
            acc <= sum;
            m   <= m + 4'd1;
            wk  <= add7(wk, mod7_5(mlen));
          end else begin
            st <= S_DONE;
          end
        end
        S_EDIV: begin
          if (!neg) begin
            acc  <= sum;
            q100 <= q100 + 7'd1;
          end else begin
            leap <= ediv_lp;
            if (dy > month_len(ediv_lp, mo - 4'd1)) begin
              vld <= 1'b0;
              st  <= S_DONE;
            end else begin
              vld <= 1'b1;
              acc <= ACC_W'(y);
              cnt <= '0;
              st  <= S_EMUL;
            end
          end
        end
        S_EMUL: begin
          acc <= sum;
          if (cnt == 5'd4) begin
            cnt <= '0;
            st  <= S_ETERM;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_ETERM: begin
          acc <= sum;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd4) begin
            m  <= '0;
            st <= S_EMON;
          end
        end
        S_EMON: begin
          if (m < mo - 4'd1) begin
            acc <= sum;
            m   <= m + 4'd1;
          end else begin
            st <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            m_tuser[0] <= vld;
            m_tdata    <= res_data;
            st         <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("invalid result carries nonzero fields");

  a_decode_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] && (m_tdata[36:23] != '0) |->
      (m_tdata[40:37] != '0) && (m_tdata[40:37] <= 4'd12) &&
      (m_tdata[45:41] != '0) && (m_tdata[48:46] != '0) && (m_tdata[22:0] == '0))
    else $error("decoded date fields out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("new word taken while conversion in flight");

  a_acc_nonneg: assert property (@(posedge clk) disable iff (rst)
    (st == S_Y100) || (st == S_Y4) || (st == S_Y1) || (st == S_MON) |->
      !acc[ACC_W-1])
    else $error("day remainder went negative");

endmodule

>>> design/serial_day_calendar_codec.sv
// Timing: the repeated subtraction of year cycles and months (decode) and of
//   centuries (encode) on one shared adder sets the conversion time.
// Flow: one word in flight at a time; the next word is taken once
//   the result has moved to the output register.
// Reset: synchronous, active high; epoch_offset returns to 693594, no result pending.
// ----------------------------------------------------------------------------
// serial_day_calendar_codec
// Gregorian date <-> signed serial day converter with an APB epoch register.
// ----------------------------------------------------------------------------
module serial_day_calendar_codec
  import sdcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // [22:0] in_serial_day, [36:23] in_year,
                                       // [40:37] in_month, [45:41] in_day
  input  logic [0:0]        s_tuser,   // [0] mode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // [22:0] out_serial_day, [36:23] out_year,
                                       // [40:37] out_month, [45:41] out_day,
                                       // [48:46] weekday, [49] leap
  output logic [0:0]        m_tuser    // [0] valid_res
);

  localparam logic [1:0] ADDR_EPOCH = 2'd0;

  logic [EPOCH_W-1:0] epoch_offset;
  logic               hit;

  assign pready = 1'b1;
  assign hit    = (paddr == ADDR_EPOCH);
  assign prdata = hit ? 32'(epoch_offset) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_offset <= EPOCH_RST;
    end else if (psel && penable && pwrite && pready && hit) begin
      epoch_offset <= pwdata[EPOCH_W-1:0];
    end
  end

  sdcc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .epoch    (epoch_offset),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
